@@ src/rmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rmc_pkg;

  // control law carried in the input tuser
  typedef enum logic [1:0] {
    MODE_TIMER  = 2'd0,
    MODE_THERMO = 2'd1,
    MODE_WINDOW = 2'd2,
    MODE_DOSING = 2'd3
  } mode_t;

  // register indexes on the config port
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_MINUTES  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_MINUTES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HYST   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_HOUR     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOUR    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TDS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS   = 4'd7;

  // minute counts are kept as millisecond thresholds, 2047 * 60000 fits in 27 bits
  localparam int unsigned MS_W = 27;
  localparam logic [MS_W-1:0] MS_PER_MIN = 27'd60000;
  localparam logic [MS_W-1:0] ON_MS_RST  = 27'd900000;
  localparam logic [MS_W-1:0] OFF_MS_RST = 27'd2700000;

  typedef struct packed {
    logic [MS_W-1:0]    on_ms;
    logic [MS_W-1:0]    off_ms;
    logic signed [15:0] target_temp;
    logic [10:0]        temp_hyst;
    logic [4:0]         on_hour;
    logic [4:0]         off_hour;
    logic [15:0]        target_tds;
    logic [31:0]        settle_ms;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic               manual_override;
    logic [31:0]        now_ms;
    logic signed [15:0] temperature;
    logic [4:0]         current_hour;
    logic [15:0]        tds_ppm;
  } item_t;

  typedef struct packed {
    logic relay_changed;
    logic feeding_active;
    logic relay_on;
  } res_t;

endpackage

`default_nettype wire

@@ src/multi_mode_relay_controller_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Multi-mode relay controller. Each input item picks one of four control laws
// through in_tuser (0 minute timer, 1 thermostat with hysteresis, 2 daily hour
// window, 3 timed nutrient dosing with a settle hold) and yields exactly one
// result item with the relay state, the feeding flag and a relay-changed
// flag. A set manual_override bit leaves all state untouched. Items run at one
// per cycle: an item is held in the input register, is evaluated by the
// control law logic against the stored relay state and timestamps, and lands
// in the result register; the state registers update on the same edge, so the
// next item already sees them. The rate is set by that single evaluation stage
// and only drops when out_tready is low. Config writes are taken every cycle
// (cfg_ready is tied high); the on and off minute counts are converted to
// millisecond thresholds as they are written. Write registers only while no
// item is in flight.
module multi_mode_relay_controller_unit
  import rmc_pkg::*;
#(
  parameter int unsigned FEED_MS = 5000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input item channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [0] manual_override, [32:1] now_ms, [48:33] temperature,
  // [53:49] current_hour, [69:54] tds_ppm, [71:70] zero
  input  wire logic [71:0]          in_tdata,
  // [1:0] mode
  input  wire logic [1:0]           in_tuser,
  // result channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [0] relay_on, [1] feeding_active, [2] relay_changed, [7:3] zero
  output logic [7:0]                out_tdata,
  // config write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  item_t item_r;
  logic  item_valid_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  advance;
  cfg_t  cfg;

  // evaluate when the result slot is free or being emptied
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.mode            <= mode_t'(in_tuser);
      item_r.manual_override <= in_tdata[0];
      item_r.now_ms          <= in_tdata[32:1];
      item_r.temperature     <= $signed(in_tdata[48:33]);
      item_r.current_hour    <= in_tdata[53:49];
      item_r.tds_ppm         <= in_tdata[69:54];
    end
  end

  rmc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rmc_ctrl_core #(
    .FEED_MS (FEED_MS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.relay_changed, res_r.feeding_active, res_r.relay_on};

endmodule

`default_nettype wire

@@ src/rmc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmc_cfg_regs
  import rmc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]          wr_data,
  output cfg_t                      cfg
);

  cfg_t            cfg_r;
  cfg_t            cfg_nxt;
  logic [MS_W-1:0] minutes_ms;

  // minutes to ms once, at write time
  assign minutes_ms = {{(MS_W-11){1'b0}}, wr_data[10:0]} * MS_PER_MIN;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_ON_MINUTES:  cfg_nxt.on_ms       = minutes_ms;
        CFG_OFF_MINUTES: cfg_nxt.off_ms      = minutes_ms;
        CFG_TARGET_TEMP: cfg_nxt.target_temp = $signed(wr_data[15:0]);
        CFG_TEMP_HYST:   cfg_nxt.temp_hyst   = wr_data[10:0];
        CFG_ON_HOUR:     cfg_nxt.on_hour     = wr_data[4:0];
        CFG_OFF_HOUR:    cfg_nxt.off_hour    = wr_data[4:0];
        CFG_TARGET_TDS:  cfg_nxt.target_tds  = wr_data[15:0];
        CFG_SETTLE_MS:   cfg_nxt.settle_ms   = wr_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_ms       <= ON_MS_RST;
      cfg_r.off_ms      <= OFF_MS_RST;
      cfg_r.target_temp <= 16'sd400;
      cfg_r.temp_hyst   <= 11'd16;
      cfg_r.on_hour     <= 5'd6;
      cfg_r.off_hour    <= 5'd18;
      cfg_r.target_tds  <= 16'd800;
      cfg_r.settle_ms   <= 32'd300000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ src/rmc_ctrl_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmc_ctrl_core
  import rmc_pkg::*;
#(
  parameter int unsigned FEED_MS = 5000
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic advance,
  input  item_t     item,
  input  cfg_t      cfg,
  output res_t      res
);

  localparam logic [31:0] FEED_MS_W = 32'(FEED_MS);

  logic        relay_r,          relay_nxt;
  logic        feeding_r,        feeding_nxt;
  logic [31:0] interval_start_r, interval_start_nxt;
  logic [31:0] feed_start_r,     feed_start_nxt;
  logic [31:0] last_feed_r,      last_feed_nxt;

  logic [31:0]        timer_base;
  logic [31:0]        timer_elapsed;
  logic [31:0]        feed_elapsed;
  logic [31:0]        settle_elapsed;
  logic signed [17:0] temp_low;
  logic signed [17:0] temp_ext;
  logic               in_window;

  assign timer_base     = (interval_start_r == 32'd0) ? item.now_ms : interval_start_r;
  assign timer_elapsed  = item.now_ms - timer_base;
  assign feed_elapsed   = item.now_ms - feed_start_r;
  assign settle_elapsed = item.now_ms - last_feed_r;
  assign temp_low       = {{2{cfg.target_temp[15]}}, cfg.target_temp}
                        - $signed({7'd0, cfg.temp_hyst});
  assign temp_ext       = {{2{item.temperature[15]}}, item.temperature};
  assign in_window      = (item.current_hour >= cfg.on_hour)
                        && (item.current_hour < cfg.off_hour);

  always_comb begin
    relay_nxt          = relay_r;
    feeding_nxt        = feeding_r;
    interval_start_nxt = interval_start_r;
    feed_start_nxt     = feed_start_r;
    last_feed_nxt      = last_feed_r;
    if (!item.manual_override) begin
      case (item.mode)
        MODE_TIMER: begin
          interval_start_nxt = timer_base;
          if (relay_r) begin
            if (timer_elapsed >= {{(32-MS_W){1'b0}}, cfg.on_ms}) begin
              relay_nxt          = 1'b0;
              interval_start_nxt = item.now_ms;
            end
          end else if ((timer_elapsed >= {{(32-MS_W){1'b0}}, cfg.off_ms})
                       || (timer_base == 32'd0)) begin
            relay_nxt          = 1'b1;
            interval_start_nxt = item.now_ms;
          end
        end
        MODE_THERMO: begin
          if (relay_r) begin
            if (temp_ext >= $signed({{2{cfg.target_temp[15]}}, cfg.target_temp}))
              relay_nxt = 1'b0;
          end else if (temp_ext <= temp_low) begin
            relay_nxt = 1'b1;
          end
        end
        MODE_WINDOW: relay_nxt = in_window;
        MODE_DOSING: begin
          if (feeding_r) begin
            if (feed_elapsed >= FEED_MS_W) begin
              relay_nxt     = 1'b0;
              feeding_nxt   = 1'b0;
              last_feed_nxt = item.now_ms;
            end
          end else if (!((last_feed_r != 32'd0) && (settle_elapsed < cfg.settle_ms))) begin
            if (item.tds_ppm < cfg.target_tds) begin
              relay_nxt      = 1'b1;
              feeding_nxt    = 1'b1;
              feed_start_nxt = item.now_ms;
            end else begin
              relay_nxt = 1'b0;
            end
          end
        end
        default: relay_nxt = relay_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r          <= 1'b1;
      feeding_r        <= 1'b0;
      interval_start_r <= 32'd0;
      feed_start_r     <= 32'd0;
      last_feed_r      <= 32'd0;
    end else if (advance) begin
      relay_r          <= relay_nxt;
      feeding_r        <= feeding_nxt;
      interval_start_r <= interval_start_nxt;
      feed_start_r     <= feed_start_nxt;
      last_feed_r      <= last_feed_nxt;
    end
  end

  assign res.relay_on       = relay_nxt;
  assign res.feeding_active = feeding_nxt;
  assign res.relay_changed  = relay_nxt ^ relay_r;

  // override leaves every piece of state alone
  a_override_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.manual_override |=>
      $stable(relay_r) && $stable(feeding_r) && $stable(interval_start_r)
      && $stable(feed_start_r) && $stable(last_feed_r))
    else $error("state changed under manual override");

  // only the dosing law touches the feeding flag
  a_feed_only_dosing: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (item.mode != MODE_DOSING) |=> $stable(feeding_r))
    else $error("feeding flag changed outside dosing mode");

  // hour window drives the relay directly
  a_window_follow: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !item.manual_override && (item.mode == MODE_WINDOW) |=>
      relay_r == $past(in_window))
    else $error("relay does not follow hour window");

  // reported change matches the stored relay
  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> $past(res.relay_changed) == (relay_r != $past(relay_r)))
    else $error("relay_changed disagrees with relay state");

endmodule

`default_nettype wire
